FILE: src/battery_voltage_to_percent_core_macros.svh
// Assertion macros shared by the checker of the battery voltage to percent core.
// Depends on nothing; the user supplies clk and rst_n in the enclosing scope.
`ifndef BATTERY_VOLTAGE_TO_PERCENT_CORE_MACROS_SVH
`define BATTERY_VOLTAGE_TO_PERCENT_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BVP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BVP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bvp_pkg.sv
// Shared types, constants and breakpoint tables of the battery voltage to percent core.
// Depends on nothing; used by the controller, the datapath and the top level.
package bvp_pkg;

  localparam int VOLT_W      = 16;
  localparam int PCT_W       = 7;
  localparam int TABLE_SLOTS = 32;
  localparam int IDX_W       = 5;
  localparam int QUO_W       = 7;
  localparam int PROD_W      = PCT_W + VOLT_W;
  localparam int DIV_W       = VOLT_W + QUO_W - 1;
  localparam int CNT_W       = 3;

  typedef logic [1:0] fix_sel_t;
  localparam fix_sel_t FIX_ZERO = 2'd0;
  localparam fix_sel_t FIX_HI   = 2'd1;
  localparam fix_sel_t FIX_LAST = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     cap;
    logic     nxt;
    logic     seg;
    logic     fix;
    fix_sel_t fix_sel;
    logic     mul;
    logic     dstep;
    logic     load_out;
  } bvp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic below;
    logic hit;
    logic dv_zero;
    logic last;
  } bvp_sts_t;

  function automatic logic [VOLT_W-1:0] volt_bp(input logic [IDX_W-1:0] idx);
    logic [VOLT_W-1:0] v;
    case (idx)
      5'd0:    v = 16'h0C7A;
      5'd1:    v = 16'h0D53;
      5'd2:    v = 16'h0D6C;
      5'd3:    v = 16'h0D9A;
      5'd4:    v = 16'h0DE1;
      5'd5:    v = 16'h0E28;
      5'd6:    v = 16'h0E39;
      5'd7:    v = 16'h0E5F;
      5'd8:    v = 16'h0EB6;
      5'd9:    v = 16'h0F12;
      5'd10:   v = 16'h0F1F;
      5'd11:   v = 16'h0F34;
      5'd12:   v = 16'h0F45;
      5'd13:   v = 16'h0F5E;
      5'd14:   v = 16'h0FD3;
      5'd15:   v = 16'h0FD7;
      5'd16:   v = 16'h0FDF;
      5'd17:   v = 16'h0FE3;
      5'd18:   v = 16'h0FE8;
      5'd19:   v = 16'h0FEC;
      default: v = 16'h1072;
    endcase
    return v;
  endfunction

  function automatic logic [PCT_W-1:0] pct_bp(input logic [IDX_W-1:0] idx);
    logic [PCT_W-1:0] p;
    case (idx)
      5'd0:    p = 7'd0;
      5'd1:    p = 7'd4;
      5'd2:    p = 7'd6;
      5'd3:    p = 7'd10;
      5'd4:    p = 7'd16;
      5'd5:    p = 7'd21;
      5'd6:    p = 7'd23;
      5'd7:    p = 7'd26;
      5'd8:    p = 7'd35;
      5'd9:    p = 7'd46;
      5'd10:   p = 7'd48;
      5'd11:   p = 7'd51;
      5'd12:   p = 7'd53;
      5'd13:   p = 7'd57;
      5'd14:   p = 7'd87;
      5'd15:   p = 7'd88;
      5'd16:   p = 7'd90;
      5'd17:   p = 7'd92;
      5'd18:   p = 7'd93;
      5'd19:   p = 7'd94;
      default: p = 7'd100;
    endcase
    return p;
  endfunction

endpackage

FILE: src/bvp_ctrl.sv
// Controller state machine of the battery voltage to percent core.
// Depends on bvp_pkg for the command and status structs.
module bvp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bvp_pkg::bvp_sts_t sts,
  output bvp_pkg::bvp_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_SRCH  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]                 state_r, state_nxt;
  logic [bvp_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.fix_sel   = bvp_pkg::FIX_ZERO;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.below) begin
          cmd.fix     = 1'b1;
          cmd.fix_sel = bvp_pkg::FIX_ZERO;
          state_nxt   = ST_DONE;
        end else begin
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (sts.hit) begin
          if (sts.dv_zero) begin
            cmd.fix     = 1'b1;
            cmd.fix_sel = bvp_pkg::FIX_HI;
            state_nxt   = ST_DONE;
          end else begin
            cmd.seg   = 1'b1;
            state_nxt = ST_MUL;
          end
        end else if (sts.last) begin
          cmd.fix     = 1'b1;
          cmd.fix_sel = bvp_pkg::FIX_LAST;
          state_nxt   = ST_DONE;
        end else begin
          cmd.nxt = 1'b1;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.dstep = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == bvp_pkg::CNT_W'(bvp_pkg::QUO_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: src/bvp_dp.sv
// Datapath of the battery voltage to percent core: search index, segment, multiply, divider.
// Depends on bvp_pkg for tables, widths and the command and status structs.
module bvp_dp #(
  parameter int POINTS = 21
) (
  input  logic                       clk,
  input  logic [bvp_pkg::VOLT_W-1:0] in_voltage,
  input  bvp_pkg::bvp_cmd_t          cmd,
  output bvp_pkg::bvp_sts_t          sts,
  output logic [bvp_pkg::PCT_W-1:0]  out_percent
);

  localparam logic [bvp_pkg::IDX_W-1:0] LAST_IDX = bvp_pkg::IDX_W'(POINTS - 1);

  logic [bvp_pkg::VOLT_W-1:0] v_r;
  logic [bvp_pkg::IDX_W-1:0]  idx_r;
  logic [bvp_pkg::PCT_W-1:0]  base_r;
  logic [bvp_pkg::PCT_W-1:0]  dp_r;
  logic [bvp_pkg::VOLT_W-1:0] off_r;
  logic [bvp_pkg::VOLT_W-1:0] dv_r;
  logic [bvp_pkg::PROD_W-1:0] rem_r;
  logic [bvp_pkg::DIV_W-1:0]  div_r;
  logic [bvp_pkg::QUO_W-1:0]  q_r;
  logic [bvp_pkg::PCT_W-1:0]  pct_r;

  logic [bvp_pkg::IDX_W-1:0]  lo_idx;
  logic [bvp_pkg::VOLT_W-1:0] hi_v, lo_v;
  logic [bvp_pkg::PCT_W-1:0]  hi_p, lo_p, fix_val;
  logic                       ge;
  logic [bvp_pkg::PCT_W:0]    sum;

  assign lo_idx = idx_r - 1'b1;
  assign hi_v   = bvp_pkg::volt_bp(idx_r);
  assign lo_v   = bvp_pkg::volt_bp(lo_idx);
  assign hi_p   = bvp_pkg::pct_bp(idx_r);
  assign lo_p   = bvp_pkg::pct_bp(lo_idx);

  assign sts.below   = v_r < bvp_pkg::volt_bp('0);
  assign sts.hit     = v_r <= hi_v;
  assign sts.dv_zero = hi_v == lo_v;
  assign sts.last    = idx_r == LAST_IDX;

  // Restoring divide: the quotient never exceeds the percent span, so seven bits do.
  assign ge  = rem_r >= bvp_pkg::PROD_W'(div_r);
  assign sum = {1'b0, base_r} + {1'b0, q_r};

  always_comb begin
    case (cmd.fix_sel)
      bvp_pkg::FIX_ZERO: fix_val = '0;
      bvp_pkg::FIX_HI:   fix_val = hi_p;
      bvp_pkg::FIX_LAST: fix_val = bvp_pkg::pct_bp(LAST_IDX);
      default:           fix_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      v_r   <= in_voltage;
      idx_r <= bvp_pkg::IDX_W'(1);
    end else if (cmd.nxt) begin
      idx_r <= idx_r + 1'b1;
    end

    if (cmd.seg) begin
      base_r <= lo_p;
      dp_r   <= (hi_p >= lo_p) ? (hi_p - lo_p) : '0;
      off_r  <= v_r - lo_v;
      dv_r   <= hi_v - lo_v;
      q_r    <= '0;
    end else if (cmd.fix) begin
      base_r <= fix_val;
      q_r    <= '0;
    end else if (cmd.dstep) begin
      q_r <= {q_r[bvp_pkg::QUO_W-2:0], ge};
    end

    if (cmd.mul) begin
      rem_r <= bvp_pkg::PROD_W'(dp_r) * bvp_pkg::PROD_W'(off_r);
      div_r <= {dv_r, {(bvp_pkg::QUO_W-1){1'b0}}};
    end else if (cmd.dstep) begin
      if (ge) begin
        rem_r <= rem_r - bvp_pkg::PROD_W'(div_r);
      end
      div_r <= div_r >> 1;
    end

    if (cmd.load_out) begin
      pct_r <= sum[bvp_pkg::PCT_W-1:0];
    end
  end

  assign out_percent = pct_r;

endmodule

FILE: src/battery_voltage_to_percent_core.sv
// Top level of the battery voltage to percent core.
// Depends on bvp_pkg, bvp_ctrl and bvp_dp.
//
// Usage: the in_ channel carries one request, a 16-bit raw voltage reading, under a
// valid/ready handshake; the out_ channel returns one 7-bit charge percentage per
// request, also under valid/ready. The reading is matched against a fixed table of
// ascending voltage breakpoints and interpolated linearly between the two points
// around it; readings below the first point give 0 and above the last give the last
// point's percentage, 100 with the default 21 points. Steps: the reading is first
// checked against the low end of the table, and a reading below it goes straight to
// the output load, as does a search that ends on a flat segment or past the last
// point. Otherwise the breakpoint search steps one table entry per cycle, then come
// the multiply, the restoring divider (seven quotient bits, one per cycle) and the
// load of the output register. One request is in work at a time; in_ready returns
// high the cycle after the result is loaded. The result sits in its own output
// register, so a new request can be accepted and computed while an earlier result
// still waits; if the receiver stalls, the finished computation holds until the
// output register frees. Synchronous reset (rst_n low) returns the controller to
// idle and clears out_valid; no table or clearing pass.
module battery_voltage_to_percent_core #(
  parameter int TABLE_POINTS = 21
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bvp_pkg::VOLT_W-1:0] in_voltage,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bvp_pkg::PCT_W-1:0]  out_percent
);

  // The number of table points in use is kept within what the table holds.
  localparam int POINTS = (TABLE_POINTS < 2) ? 2 :
                          ((TABLE_POINTS > bvp_pkg::TABLE_SLOTS) ? bvp_pkg::TABLE_SLOTS :
                           TABLE_POINTS);

  bvp_pkg::bvp_cmd_t cmd;
  bvp_pkg::bvp_sts_t sts;

  // The controller sequences check, search, multiply, divide and output load.
  bvp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the reading, the search index, the segment and the divider.
  bvp_dp #(
    .POINTS (POINTS)
  ) u_dp (
    .clk         (clk),
    .in_voltage  (in_voltage),
    .cmd         (cmd),
    .sts         (sts),
    .out_percent (out_percent)
  );

endmodule

FILE: src/bvp_checker.sv
// Port-level checker of the battery voltage to percent core, bound to the top level.
// Depends on battery_voltage_to_percent_core_macros.svh for the assertion macros.
`include "battery_voltage_to_percent_core_macros.svh"

module bvp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [6:0] out_percent,
  input logic       out_valid,
  input logic       out_ready
);

  // A delivered percentage never exceeds full charge.
  `BVP_ASSERT_NOW(a_pct_range, out_valid, out_percent <= 7'd100, "percent above 100")

  // The block works on one request at a time, so it is busy right after an acceptance.
  `BVP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

  // A stalled result stays valid and unchanged.
  `BVP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_percent),
    "stalled result changed")

endmodule

bind battery_voltage_to_percent_core bvp_checker u_bvp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_percent (out_percent),
  .out_valid   (out_valid),
  .out_ready   (out_ready)
);
